/* rtl/c2s_pkg.sv */
// Shared constants, types and tables of the Cartesian to spherical converter.
package c2s_pkg;

  localparam int COORD_W       = 24;
  localparam int SQ_W          = 48;
  localparam int RAD_W         = 64;
  localparam int SQRT_STAGES   = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CD_RUN        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int SH_W          = $clog2(TABLE_LEN);
  localparam int CD_W          = 52;
  localparam int ANG_W         = 34;
  localparam int LIM_W         = 16;
  localparam int RADIUS_W      = 24;
  localparam int POLAR_W       = 15;
  localparam int AZIM_W        = 16;
  localparam int Q13_W         = ANG_W - 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ORIGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_AXIS   = 1'd1;
  localparam logic [LIM_W-1:0]     LIMIT_RESET     = 16'd26;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] ROUND_HALF  = 34'sd32768;
  localparam logic signed [Q13_W-1:0] PI_Q13      = 18'sd25736;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
  } sq_lane_t;

  typedef struct packed {
    logic signed [CD_W-1:0]  xv;
    logic signed [CD_W-1:0]  yv;
    logic signed [ANG_W-1:0] ang;
  } cd_lane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      origin_ok;
    logic                      axis_near;
  } side_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                origin_ok;
    logic                axis_near;
  } tail_t;

  // Elementary angles atan(2^-i) in Q.29 radians.
  function automatic logic signed [ANG_W-1:0] atan_q29(input int i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      0:  v = 34'sd421657428;
      1:  v = 34'sd248918915;
      2:  v = 34'sd131521918;
      3:  v = 34'sd66762579;
      4:  v = 34'sd33510843;
      5:  v = 34'sd16771758;
      6:  v = 34'sd8387925;
      7:  v = 34'sd4194219;
      8:  v = 34'sd2097141;
      9:  v = 34'sd1048575;
      10: v = 34'sd524288;
      11: v = 34'sd262144;
      12: v = 34'sd131072;
      13: v = 34'sd65536;
      14: v = 34'sd32768;
      15: v = 34'sd16384;
      16: v = 34'sd8192;
      17: v = 34'sd4096;
      18: v = 34'sd2048;
      19: v = 34'sd1024;
      20: v = 34'sd512;
      21: v = 34'sd256;
      22: v = 34'sd128;
      23: v = 34'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/c2s_if.sv */
// Valid/ready channel interfaces for points in and spherical results out.
interface c2s_in_if import c2s_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;

  modport source(output valid, output x_coord, output y_coord, output z_coord, input ready);
  modport sink(input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

interface c2s_out_if import c2s_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [RADIUS_W-1:0]      radius;
  logic [POLAR_W-1:0]       polar_angle;
  logic signed [AZIM_W-1:0] azimuth;

  modport source(output valid, output radius, output polar_angle, output azimuth, input ready);
  modport sink(input valid, input radius, input polar_angle, input azimuth, output ready);
endinterface

/* rtl/cartesian_to_spherical.sv */
// Cartesian to spherical conversion: squares, square-root chain, two CORDIC chains.
// An accepted input beat passes a squares stage, a sums stage, 32 square-root cells,
// a quadrant fold, 16 CORDIC cells and 1 output stage on its way to its result beat.
// Throughput is one point per cycle; the whole pipeline stalls only while a result waits.
// Reset is synchronous and active low; it empties the pipeline and sets both limits to 26.
module cartesian_to_spherical import c2s_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  c2s_in_if.sink               in_ch,
  c2s_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_wdata
);

  logic                en;
  logic [LIM_W-1:0]    origin_lim_r;
  logic [LIM_W-1:0]    axis_lim_r;
  logic [2*LIM_W-1:0]  lim2_r;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_lim_r <= LIMIT_RESET;
      axis_lim_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEAR_ORIGIN: origin_lim_r <= cfg_wdata;
        REG_NEAR_AXIS:   axis_lim_r   <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim2_r <= origin_lim_r * origin_lim_r;
  end

  // Stage 1: magnitudes, squares and the near-axis test.
  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] ay;
  logic [COORD_W-1:0] az;
  logic               v1_r;
  logic [SQ_W-1:0]    sqx_r;
  logic [SQ_W-1:0]    sqy_r;
  logic [SQ_W-1:0]    sqz_r;
  side_t              sd1_r;

  assign ax = in_ch.x_coord[COORD_W-1] ? -in_ch.x_coord : in_ch.x_coord;
  assign ay = in_ch.y_coord[COORD_W-1] ? -in_ch.y_coord : in_ch.y_coord;
  assign az = in_ch.z_coord[COORD_W-1] ? -in_ch.z_coord : in_ch.z_coord;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r           <= ax * ax;
      sqy_r           <= ay * ay;
      sqz_r           <= az * az;
      sd1_r.x         <= in_ch.x_coord;
      sd1_r.y         <= in_ch.y_coord;
      sd1_r.z         <= in_ch.z_coord;
      sd1_r.origin_ok <= 1'b0;
      sd1_r.axis_near <= (ax < COORD_W'(axis_lim_r)) && (ay < COORD_W'(axis_lim_r));
    end
  end

  // Stage 2: sums of squares and the near-origin test.
  logic [RAD_W-1:0] sxy;
  logic [RAD_W-1:0] sum;
  logic             v2_r;
  sq_lane_t         ln0_r;
  sq_lane_t         ln1_r;
  side_t            sd0_r;
  sq_lane_t         ln0 [SQRT_STAGES+1];
  sq_lane_t         ln1 [SQRT_STAGES+1];
  side_t            sd  [SQRT_STAGES+1];
  logic             sv  [SQRT_STAGES+1];

  assign sxy = RAD_W'(sqx_r) + RAD_W'(sqy_r);
  assign sum = sxy + RAD_W'(sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln0_r.rem       <= sum;
      ln0_r.root      <= '0;
      ln1_r.rem       <= sxy << 16;
      ln1_r.root      <= '0;
      sd0_r.x         <= sd1_r.x;
      sd0_r.y         <= sd1_r.y;
      sd0_r.z         <= sd1_r.z;
      sd0_r.origin_ok <= sum >= RAD_W'(lim2_r);
      sd0_r.axis_near <= sd1_r.axis_near;
    end
  end

  assign ln0[0] = ln0_r;
  assign ln1[0] = ln1_r;
  assign sd[0]  = sd0_r;
  assign sv[0]  = v2_r;

  // Square-root chain: lane 0 gives the radius, lane 1 rho in Q.8.
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [RAD_W-1:0] BIT_K = RAD_W'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic  sv_r;
    side_t sd_r;

    c2s_sqrt_cell u_cell (
      .clk       (clk),
      .en        (en),
      .stage_bit (BIT_K),
      .lane0_in  (ln0[k]),
      .lane1_in  (ln1[k]),
      .lane0_out (ln0[k+1]),
      .lane1_out (ln1[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r <= 1'b0;
      end else if (en) begin
        sv_r <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r <= sd[k];
      end
    end

    assign sv[k+1] = sv_r;
    assign sd[k+1] = sd_r;
  end

  // Quadrant fold ahead of both CORDIC chains.
  function automatic cd_lane_t fold(input logic signed [CD_W-1:0] xv,
                                    input logic signed [CD_W-1:0] yv);
    cd_lane_t o;
    o.xv  = xv;
    o.yv  = yv;
    o.ang = '0;
    if (xv < 0) begin
      if (yv >= 0) begin
        o.xv  = yv;
        o.yv  = -xv;
        o.ang = ANG_HALF_PI;
      end else begin
        o.xv  = -yv;
        o.yv  = xv;
        o.ang = -ANG_HALF_PI;
      end
    end
    return o;
  endfunction

  side_t                  sq_last;
  sq_lane_t               r_lane;
  logic [RADIUS_W-1:0]    radius_rnd;
  logic signed [CD_W-1:0] pol_x;
  logic signed [CD_W-1:0] pol_y;
  logic signed [CD_W-1:0] az_x;
  logic signed [CD_W-1:0] az_y;
  logic                   pv_r;
  cd_lane_t               cpol0_r;
  cd_lane_t               caz0_r;
  tail_t                  tl0_r;
  cd_lane_t               cpol [CD_RUN+1];
  cd_lane_t               caz  [CD_RUN+1];
  tail_t                  tl   [CD_RUN+1];
  logic                   tv   [CD_RUN+1];

  assign sq_last    = sd[SQRT_STAGES];
  assign r_lane     = ln0[SQRT_STAGES];
  // The remainder is sum - r*r, so rounding to nearest is a compare against r.
  assign radius_rnd = r_lane.root[RADIUS_W-1:0] +
                      RADIUS_W'(r_lane.rem > r_lane.root);
  assign pol_x = {{(CD_W-COORD_W-24){sq_last.z[COORD_W-1]}}, sq_last.z, 24'b0};
  assign pol_y = {4'b0, ln1[SQRT_STAGES].root[CD_W-21:0], 16'b0};
  assign az_x  = {{(CD_W-COORD_W-24){sq_last.x[COORD_W-1]}}, sq_last.x, 24'b0};
  assign az_y  = {{(CD_W-COORD_W-24){sq_last.y[COORD_W-1]}}, sq_last.y, 24'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= sv[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpol0_r         <= fold(pol_x, pol_y);
      caz0_r          <= fold(az_x, az_y);
      tl0_r.radius    <= radius_rnd;
      tl0_r.origin_ok <= sq_last.origin_ok;
      tl0_r.axis_near <= sq_last.axis_near;
    end
  end

  assign cpol[0] = cpol0_r;
  assign caz[0]  = caz0_r;
  assign tl[0]   = tl0_r;
  assign tv[0]   = pv_r;

  for (genvar k = 0; k < CD_RUN; k++) begin : g_cordic
    localparam logic signed [ANG_W-1:0] ATAN_K = atan_q29(k);
    localparam logic [SH_W-1:0]         SH_K   = SH_W'(k);
    logic  tv_r;
    tail_t tl_r;

    c2s_cordic_cell u_pol (
      .clk       (clk),
      .en        (en),
      .shift     (SH_K),
      .atan_step (ATAN_K),
      .lane_in   (cpol[k]),
      .lane_out  (cpol[k+1])
    );

    c2s_cordic_cell u_az (
      .clk       (clk),
      .en        (en),
      .shift     (SH_K),
      .atan_step (ATAN_K),
      .lane_in   (caz[k]),
      .lane_out  (caz[k+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tv_r <= 1'b0;
      end else if (en) begin
        tv_r <= tv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tl_r <= tl[k];
      end
    end

    assign tv[k+1] = tv_r;
    assign tl[k+1] = tl_r;
  end

  // Output stage: round Q.29 to Q.13, clamp, and apply the near-origin and near-axis rules.
  logic signed [ANG_W-1:0] pol_t;
  logic signed [ANG_W-1:0] az_t;
  logic signed [Q13_W-1:0] pol_q;
  logic signed [Q13_W-1:0] az_q;
  logic [POLAR_W-1:0]      polar_nxt;
  logic signed [AZIM_W-1:0] azim_nxt;
  tail_t                   tl_last;
  logic                    out_v_r;
  logic [RADIUS_W-1:0]     radius_r;
  logic [POLAR_W-1:0]      polar_r;
  logic signed [AZIM_W-1:0] azim_r;

  assign tl_last = tl[CD_RUN];
  assign pol_t   = cpol[CD_RUN].ang + ROUND_HALF;
  assign az_t    = caz[CD_RUN].ang + ROUND_HALF;
  assign pol_q   = pol_t[ANG_W-1:16];
  assign az_q    = az_t[ANG_W-1:16];

  always_comb begin
    priority if (!tl_last.origin_ok) begin
      polar_nxt = '0;
    end else if (pol_q < 0) begin
      polar_nxt = '0;
    end else if (pol_q > PI_Q13) begin
      polar_nxt = POLAR_W'(PI_Q13);
    end else begin
      polar_nxt = pol_q[POLAR_W-1:0];
    end
    priority if (!tl_last.origin_ok || tl_last.axis_near) begin
      azim_nxt = '0;
    end else if (az_q < -PI_Q13) begin
      azim_nxt = AZIM_W'(-PI_Q13);
    end else if (az_q > PI_Q13) begin
      azim_nxt = AZIM_W'(PI_Q13);
    end else begin
      azim_nxt = az_q[AZIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= tv[CD_RUN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radius_r <= tl_last.radius;
      polar_r  <= polar_nxt;
      azim_r   <= azim_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.radius      = radius_r;
  assign out_ch.polar_angle = polar_r;
  assign out_ch.azimuth     = azim_r;

endmodule

/* rtl/c2s_sqrt_cell.sv */
// One digit of a pipelined square root, two independent lanes.
module c2s_sqrt_cell import c2s_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [RAD_W-1:0] stage_bit,
  input  sq_lane_t         lane0_in,
  input  sq_lane_t         lane1_in,
  output sq_lane_t         lane0_out,
  output sq_lane_t         lane1_out
);

  sq_lane_t lane0_nxt;
  sq_lane_t lane1_nxt;
  sq_lane_t lane0_r;
  sq_lane_t lane1_r;

  function automatic sq_lane_t digit(input sq_lane_t l, input logic [RAD_W-1:0] b);
    sq_lane_t o;
    logic [RAD_W-1:0] trial;
    trial = l.root + b;
    if (l.rem >= trial) begin
      o.rem  = l.rem - trial;
      o.root = (l.root >> 1) + b;
    end else begin
      o.rem  = l.rem;
      o.root = l.root >> 1;
    end
    return o;
  endfunction

  always_comb begin
    lane0_nxt = digit(lane0_in, stage_bit);
    lane1_nxt = digit(lane1_in, stage_bit);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane0_r <= lane0_nxt;
      lane1_r <= lane1_nxt;
    end
  end

  assign lane0_out = lane0_r;
  assign lane1_out = lane1_r;

endmodule

/* rtl/c2s_cordic_cell.sv */
// One micro-rotation of a CORDIC vectoring pipeline.
module c2s_cordic_cell import c2s_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SH_W-1:0]         shift,
  input  logic signed [ANG_W-1:0] atan_step,
  input  cd_lane_t                lane_in,
  output cd_lane_t                lane_out
);

  logic signed [CD_W-1:0] xi;
  logic signed [CD_W-1:0] yi;
  logic signed [CD_W-1:0] dx;
  logic signed [CD_W-1:0] dy;
  cd_lane_t               lane_nxt;
  cd_lane_t               lane_r;

  assign xi = lane_in.xv;
  assign yi = lane_in.yv;
  assign dx = yi >>> shift;
  assign dy = xi >>> shift;

  // Rotate toward the x axis; y equal to zero counts as positive.
  always_comb begin
    if (!yi[CD_W-1]) begin
      lane_nxt.xv  = xi + dx;
      lane_nxt.yv  = yi - dy;
      lane_nxt.ang = lane_in.ang + atan_step;
    end else begin
      lane_nxt.xv  = xi - dx;
      lane_nxt.yv  = yi + dy;
      lane_nxt.ang = lane_in.ang - atan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

/* dv/cartesian_to_spherical_tb.sv */
// Self-checking testbench for the Cartesian to spherical converter.
`timescale 1ns / 1ps

module cartesian_to_spherical_tb;
  import c2s_pkg::*;

  typedef struct packed {
    logic [RADIUS_W-1:0]      radius;
    logic [POLAR_W-1:0]       polar_angle;
    logic signed [AZIM_W-1:0] azimuth;
  } sph_t;

  localparam int  PIPE_DRAIN = 60;
  localparam longint PI_Q13_L = 25736;
  localparam longint HALF_PI_Q29 = 843314857;
  localparam longint ATAN_TBL [24] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925, 4194219,
    2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
    8192, 4096, 2048, 1024, 512, 256, 128, 64};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_NEAR_ORIGIN;
  logic [LIM_W-1:0] cfg_wdata = '0;

  c2s_in_if  in_ch();
  c2s_out_if out_ch();

  cartesian_to_spherical u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  sph_t pending_results[$];
  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  bit gapless = 1'b0;
  int unsigned hold_cycles = 0;
  longint unsigned origin_lim = LIMIT_RESET;
  longint unsigned axis_lim = LIMIT_RESET;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_coord = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic longint unsigned isqrt_u64(input longint unsigned s);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC, Q.29 angle; a zero y counts as positive.
  function automatic longint vector_angle(input longint xv, input longint yv);
    longint ang = 0;
    longint t, dx, dy;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = HALF_PI_Q29;
      end else begin
        xv = -yv; yv = t; ang = -HALF_PI_Q29;
      end
    end
    for (int i = 0; i < CD_RUN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += ATAN_TBL[i];
      end else begin
        xv -= dx; yv += dy; ang -= ATAN_TBL[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_q13(input longint ang, input longint lo, input longint hi);
    longint r = (ang + 32768) >>> 16;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic sph_t predict_spherical(input logic signed [COORD_W-1:0] xi,
                                             input logic signed [COORD_W-1:0] yi,
                                             input logic signed [COORD_W-1:0] zi);
    longint x = xi, y = yi, z = zi;
    longint unsigned ax = (x < 0) ? -x : x;
    longint unsigned ay = (y < 0) ? -y : y;
    longint unsigned az = (z < 0) ? -z : z;
    longint unsigned sxy = ax * ax + ay * ay;
    longint unsigned sum = sxy + az * az;
    longint unsigned r = isqrt_u64(sum);
    longint unsigned rho16;
    longint polar = 0, azim = 0;
    sph_t res;
    if (sum - r * r > r) r++;
    if (sum >= origin_lim * origin_lim) begin
      rho16 = isqrt_u64(sxy << 16);
      polar = round_q13(vector_angle(z * 64'sd16777216, longint'(rho16) * 64'sd65536),
                        0, PI_Q13_L);
      if (!(ax < axis_lim && ay < axis_lim))
        azim = round_q13(vector_angle(x * 64'sd16777216, y * 64'sd16777216),
                         -PI_Q13_L, PI_Q13_L);
    end
    res.radius = r[RADIUS_W-1:0];
    res.polar_angle = polar[POLAR_W-1:0];
    res.azimuth = azim[AZIM_W-1:0];
    return res;
  endfunction

  task automatic send_point(input logic signed [COORD_W-1:0] xi,
                            input logic signed [COORD_W-1:0] yi,
                            input logic signed [COORD_W-1:0] zi);
    if (!gapless && burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid = 1'b1;
    in_ch.x_coord = xi;
    in_ch.y_coord = yi;
    in_ch.z_coord = zi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_spherical(xi, yi, zi));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_NEAR_ORIGIN) origin_lim = val;
    else axis_lim = val;
  endtask

  task automatic random_point(output logic signed [COORD_W-1:0] xi,
                              output logic signed [COORD_W-1:0] yi,
                              output logic signed [COORD_W-1:0] zi);
    case ($urandom_range(0, 5))
      0, 1: begin
        xi = COORD_W'($urandom); yi = COORD_W'($urandom); zi = COORD_W'($urandom);
      end
      2: begin
        xi = COORD_W'($urandom_range(0, 127) - 64);
        yi = COORD_W'($urandom_range(0, 127) - 64);
        zi = COORD_W'($urandom_range(0, 127) - 64);
      end
      3: begin
        xi = COORD_W'($urandom_range(0, 63) - 32);
        yi = COORD_W'($urandom_range(0, 63) - 32);
        zi = COORD_W'($urandom);
      end
      4: begin
        xi = -$signed({1'b0, 23'($urandom)});
        yi = '0;
        zi = COORD_W'($urandom);
      end
      default: begin
        xi = COORD_W'($urandom_range(0, 8191) - 4096);
        yi = COORD_W'($urandom_range(0, 8191) - 4096);
        zi = COORD_W'($urandom_range(0, 8191) - 4096);
      end
    endcase
  endtask

  task automatic test_directed();
    send_point(0, 0, 0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(-24'sh800000, -24'sh800000, -24'sh800000);
    send_point(-24'sh800000, 0, 0);
    send_point(24'sh7FFFFF, 0, 0);
    send_point(0, 24'sh7FFFFF, 0);
    send_point(0, -24'sh800000, 0);
    send_point(0, 0, 24'sh7FFFFF);
    send_point(0, 0, -24'sh800000);
    send_point(-1000, 0, 500);       // negative x on the x axis
    send_point(-1000, -1, 500);
    send_point(-1000, 1, 500);
    send_point(10, 10, 10);          // inside the default origin sphere
    send_point(15, 15, 15);          // just inside it too
    send_point(26, 0, 0);
    send_point(25, 25, 3000);        // close to the z axis
    send_point(25, 26, 3000);
    send_point(-25, -25, -3000);
    send_point(1, 1, 0);
    send_point(-3, 4, -12);
    send_point(24'sh7FFFFF, -24'sh800000, 1);
    wait_idle();
  endtask

  task automatic test_limit_settings();
    logic signed [COORD_W-1:0] xi, yi, zi;
    write_limit(REG_NEAR_ORIGIN, '0);
    write_limit(REG_NEAR_AXIS, '0);
    send_point(0, 0, 0);
    send_point(0, 0, -5);
    send_point(-1, 0, 0);
    repeat (40) begin
      random_point(xi, yi, zi);
      send_point(xi, yi, zi);
    end
    wait_idle();
    write_limit(REG_NEAR_ORIGIN, 16'hFFFF);
    write_limit(REG_NEAR_AXIS, 16'hFFFF);
    send_point(65534, 0, 0);
    send_point(65535, 0, 0);
    send_point(0, 0, -65535);
    repeat (80) begin
      random_point(xi, yi, zi);
      send_point(xi, yi, zi);
    end
    wait_idle();
  endtask

  task automatic test_random(input int n);
    logic signed [COORD_W-1:0] xi, yi, zi;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        wait_idle();
        write_limit(REG_NEAR_ORIGIN, LIM_W'($urandom_range(0, 3) == 0 ?
                                           $urandom : $urandom_range(0, 80)));
        write_limit(REG_NEAR_AXIS, LIM_W'($urandom_range(0, 3) == 0 ?
                                         $urandom : $urandom_range(0, 80)));
      end
      gapless = ($urandom_range(0, 9) == 0);
      random_point(xi, yi, zi);
      send_point(xi, yi, zi);
    end
    gapless = 1'b0;
    wait_idle();
  endtask

  // Output held off long enough to fill the pipeline and stall the input side.
  task automatic test_backpressure();
    logic signed [COORD_W-1:0] xi, yi, zi;
    write_limit(REG_NEAR_ORIGIN, LIMIT_RESET);
    write_limit(REG_NEAR_AXIS, LIMIT_RESET);
    gapless = 1'b1;
    hold_cycles = 150;
    repeat (120) begin
      random_point(xi, yi, zi);
      send_point(xi, yi, zi);
    end
    gapless = 1'b0;
    wait_idle();
  endtask

  // Receiver: a stall pattern that changes mode every so often, plus forced hold-offs.
  initial begin : rx_ready_gen
    int unsigned mode = 0;
    int unsigned mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = (mode_left % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sph_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.radius !== want.radius)
          report_mismatch($sformatf("radius %0d, expected %0d", out_ch.radius, want.radius));
        if (out_ch.polar_angle !== want.polar_angle)
          report_mismatch($sformatf("polar_angle %0d, expected %0d",
                                    out_ch.polar_angle, want.polar_angle));
        if (out_ch.azimuth !== want.azimuth)
          report_mismatch($sformatf("azimuth %0d, expected %0d",
                                    out_ch.azimuth, want.azimuth));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_limit_settings();
    test_backpressure();
    test_random(880);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("cartesian_to_spherical_tb: done, clean");
    end else begin
      $display("cartesian_to_spherical_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TIMEOUT @%0t", $time);
    $display("cartesian_to_spherical_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/c2s_pkg.sv
rtl/c2s_if.sv
rtl/c2s_sqrt_cell.sv
rtl/c2s_cordic_cell.sv
rtl/cartesian_to_spherical.sv
dv/cartesian_to_spherical_tb.sv
